### rtl/core/bnbs_pkg.sv
// Shared types and constants for the banknote breakdown pipeline.
// Depends on nothing; used by the channel interfaces, the stage module and the top level.
`timescale 1ns / 1ps

package bnbs_pkg;

  localparam int unsigned NUM_DENOMS = 6;
  // lane 0 is the plain greedy pass, lanes 1..6 each leave out one note (10 first)
  localparam int unsigned NUM_LANES  = 7;
  localparam int unsigned AMT_W      = 16;
  localparam int unsigned CNT_W      = 12;
  localparam int unsigned Q_W        = 13;  // largest quotient is 65535 / 10
  localparam int unsigned REG_IDX_W  = 3;
  localparam int unsigned APB_AW     = 5;
  localparam int unsigned APB_DW     = 32;

  // reciprocal estimate: q_est = (rest * RECIP) >> RECIP_SHIFT, low by at most one
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned RECIP_W     = 21;
  localparam int unsigned PROD_W      = AMT_W + RECIP_W;

  localparam logic [AMT_W-1:0] DENOM [NUM_DENOMS] = '{
    16'd500, 16'd200, 16'd100, 16'd50, 16'd20, 16'd10
  };

  // floor(2^24 / denomination)
  localparam logic [RECIP_W-1:0] RECIP [NUM_DENOMS] = '{
    21'd33554, 21'd83886, 21'd167772, 21'd335544, 21'd838860, 21'd1677721
  };

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [Q_W-1:0]   quot_t;

  typedef struct packed {
    logic [AMT_W-1:0]            rest;
    cnt_t [NUM_DENOMS-1:0]       cnt;   // cnt[i] belongs to DENOM[i]
  } lane_t;

  typedef lane_t [NUM_LANES-1:0] work_t;
  typedef quot_t [NUM_LANES-1:0] quot_vec_t;

  // true where the given lane leaves out the given denomination
  function automatic logic lane_skips(input int unsigned lane, input int unsigned didx);
    lane_skips = (lane != 0) && (didx == NUM_LANES - 1 - lane);
  endfunction

endpackage

### rtl/core/bnbs_in_if.sv
// Request channel: one amount word per handshake.
// Depends on bnbs_pkg for the field width.
`timescale 1ns / 1ps

interface bnbs_in_if import bnbs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [AMT_W-1:0] amount;

  modport source (output valid, output amount, input ready);
  modport sink   (input valid, input amount, output ready);
endinterface

### rtl/core/bnbs_out_if.sv
// Result channel: ok flag and six note counts per word.
// Depends on bnbs_pkg for the field widths.
`timescale 1ns / 1ps

interface bnbs_out_if import bnbs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic       ok;
  logic [CNT_W-1:0] count_500;
  logic [CNT_W-1:0] count_200;
  logic [CNT_W-1:0] count_100;
  logic [CNT_W-1:0] count_50;
  logic [CNT_W-1:0] count_20;
  logic [CNT_W-1:0] count_10;

  modport source (output valid, output ok, output count_500, output count_200,
                  output count_100, output count_50, output count_20, output count_10,
                  input ready);
  modport sink   (input valid, input ok, input count_500, input count_200,
                  input count_100, input count_50, input count_20, input count_10,
                  output ready);
endinterface

### rtl/core/bnbs_denom_stage.sv
// One denomination step for all seven passes, two register stages:
// reciprocal quotient estimate, then correction and stock check. Depends on bnbs_pkg.
`timescale 1ns / 1ps

module bnbs_denom_stage import bnbs_pkg::*; #(
  parameter int unsigned DENOM_IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CNT_W-1:0] stock,
  input  logic             in_valid,
  output logic             in_ready,
  input  work_t            in_work,
  output logic             out_valid,
  input  logic             out_ready,
  output work_t            out_work
);

  localparam logic [PROD_W-1:0] RECIP_EXT = {{(PROD_W-RECIP_W){1'b0}}, RECIP[DENOM_IDX]};
  localparam logic [AMT_W:0]    DVAL      = {1'b0, DENOM[DENOM_IDX]};

  logic      a_valid;
  logic      a_ready;
  work_t     a_work;
  quot_vec_t a_quot;
  quot_vec_t quot_est;

  logic      b_valid;
  logic      b_ready;
  work_t     b_work;
  work_t     b_work_next;

  assign a_ready   = !a_valid || b_ready;
  assign b_ready   = !b_valid || out_ready;
  assign in_ready  = a_ready;
  assign out_valid = b_valid;
  assign out_work  = b_work;

  for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
    logic [PROD_W-1:0] prod;
    logic [AMT_W:0]    qd;
    logic [AMT_W:0]    rem;
    logic              fix;
    quot_t             qf;
    logic [AMT_W:0]    remf;

    assign prod        = {{(PROD_W-AMT_W){1'b0}}, in_work[l].rest} * RECIP_EXT;
    assign quot_est[l] = prod[RECIP_SHIFT +: Q_W];

    // estimate may be one low: one compare and subtract fixes it
    assign qd   = {{(AMT_W+1-Q_W){1'b0}}, a_quot[l]} * DVAL;
    assign rem  = {1'b0, a_work[l].rest} - qd;
    assign fix  = (rem >= DVAL);
    assign qf   = a_quot[l] + {{(Q_W-1){1'b0}}, fix};
    assign remf = fix ? (rem - DVAL) : rem;

    always_comb begin
      b_work_next[l] = a_work[l];
      // whole quotient or nothing; a too-small rest gives a zero quotient
      if (!lane_skips(l, DENOM_IDX) && (qf <= {1'b0, stock})) begin
        b_work_next[l].cnt[DENOM_IDX] = qf[CNT_W-1:0];
        b_work_next[l].rest           = remf[AMT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= in_valid;
      if (b_ready) b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_work <= in_work;
      a_quot <= quot_est;
    end
    if (b_ready && a_valid) begin
      b_work <= b_work_next;
    end
  end

endmodule

### rtl/core/banknote_breakdown_with_stock.sv
// Banknote breakdown with per-note stock limits, seven greedy passes in parallel lanes.
// Pipeline: two register stages per note, then one select stage, from accepted amount to result.
// Throughput: one word per cycle; every stage holds its word while the next is full.
// Reset: synchronous, clears all valid bits and the six stock registers to zero.
// Depends on bnbs_pkg, bnbs_in_if, bnbs_out_if and bnbs_denom_stage.
`timescale 1ns / 1ps

module banknote_breakdown_with_stock import bnbs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready,
  bnbs_in_if.sink            in_ch,
  bnbs_out_if.source         out_ch
);

  cnt_t stock [NUM_DENOMS];

  logic [REG_IDX_W-1:0] reg_idx;
  logic                 cfg_wr;

  assign reg_idx = paddr[REG_IDX_W+1:2];
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_DENOMS; i++) stock[i] <= '0;
    end else if (cfg_wr && (reg_idx < REG_IDX_W'(NUM_DENOMS))) begin
      stock[reg_idx] <= pwdata[CNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx < REG_IDX_W'(NUM_DENOMS)) begin
      prdata = {{(APB_DW-CNT_W){1'b0}}, stock[reg_idx]};
    end
  end

  // stage chain
  logic  st_valid [NUM_DENOMS+1];
  logic  st_ready [NUM_DENOMS+1];
  work_t st_work  [NUM_DENOMS+1];

  assign st_valid[0] = in_ch.valid;
  assign in_ch.ready = st_ready[0];

  always_comb begin
    for (int l = 0; l < NUM_LANES; l++) begin
      st_work[0][l].rest = in_ch.amount;
      st_work[0][l].cnt  = '0;
    end
  end

  for (genvar d = 0; d < NUM_DENOMS; d++) begin : g_denom
    bnbs_denom_stage #(.DENOM_IDX(d)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .stock     (stock[d]),
      .in_valid  (st_valid[d]),
      .in_ready  (st_ready[d]),
      .in_work   (st_work[d]),
      .out_valid (st_valid[d+1]),
      .out_ready (st_ready[d+1]),
      .out_work  (st_work[d+1])
    );
  end

  // pick the first pass that left nothing over
  logic  sel_ok;
  lane_t sel_lane;
  logic  o_valid;
  logic  o_ok;
  cnt_t [NUM_DENOMS-1:0] o_cnt;

  always_comb begin
    sel_ok   = 1'b0;
    sel_lane = '0;
    for (int l = NUM_LANES - 1; l >= 0; l--) begin
      if (st_work[NUM_DENOMS][l].rest == '0) begin
        sel_ok   = 1'b1;
        sel_lane = st_work[NUM_DENOMS][l];
      end
    end
  end

  assign st_ready[NUM_DENOMS] = !o_valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (st_ready[NUM_DENOMS]) begin
      o_valid <= st_valid[NUM_DENOMS];
    end
  end

  always_ff @(posedge clk) begin
    if (st_ready[NUM_DENOMS] && st_valid[NUM_DENOMS]) begin
      o_ok  <= sel_ok;
      o_cnt <= sel_ok ? sel_lane.cnt : '0;
    end
  end

  assign out_ch.valid     = o_valid;
  assign out_ch.ok        = o_ok;
  assign out_ch.count_500 = o_cnt[0];
  assign out_ch.count_200 = o_cnt[1];
  assign out_ch.count_100 = o_cnt[2];
  assign out_ch.count_50  = o_cnt[3];
  assign out_ch.count_20  = o_cnt[4];
  assign out_ch.count_10  = o_cnt[5];

`ifndef ASSERT_OFF
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ok) |-> (o_cnt == '0))
    else $error("failed breakdown carries nonzero counts");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with empty output register");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_ch.valid)
    else $error("result word valid right after reset");
`endif

endmodule
